FILE: rtl/rcfu_pkg.sv
// Shared types and constants for the remote-control frame unpacker.
`default_nettype none

package rcfu_pkg;

    // Frame geometry
    localparam int FRAME_USED_BYTES = 16;

    // Field widths
    localparam int STICK_W = 11;
    localparam int OFF_W   = 12;
    localparam int DEAD_W  = 6;
    localparam int KEY_W   = 16;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [STICK_W-1:0] CENTER_RESET = 11'd1024;
    localparam logic [DEAD_W-1:0]  DEAD_RESET   = 6'd6;

    // Register indexes (word address bit of paddr)
    typedef enum logic {
        REG_STICK_CENTER = 1'b0,
        REG_DEADBAND     = 1'b1
    } reg_idx_t;

    // Query answers
    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_code_t;

    // Commands of an input item
    typedef enum logic {
        CMD_FRAME_BYTE = 1'b0,
        CMD_KEY_QUERY  = 1'b1
    } cmd_t;

    // Control broadcast to every byte cell
    typedef struct packed {
        logic shift;    // a frame byte is accepted this cycle
        logic restart;  // that byte ends the frame
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/rc_frame_unpack_edges.sv
// Top level of the remote-control frame unpacker with key-edge tracking.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   command, frame_byte, frame_end, key_mask
//  result    out        result_valid/result_stall sticks, switches, mouse, keys, edge_code
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One item per cycle. A frame end or query shows its result in the cycle after acceptance,
// from a single output register fed by the byte-cell row and the stick units.
// Frame bytes without end are taken even while a result waits; a result-producing
// item is held off only while the output register is full and stalled.
// Reset clears the byte row, the key state and the registers at once; no sweep.
`default_nettype none

module rc_frame_unpack_edges (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Input items
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic                         command,
    input  wire logic [7:0]                   frame_byte,
    input  wire logic                         frame_end,
    input  wire logic [15:0]                  key_mask,
    // Result items
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic signed [11:0]                stick_a,
    output logic signed [11:0]                stick_b,
    output logic signed [11:0]                stick_c,
    output logic signed [11:0]                stick_d,
    output logic [3:0]                        switches,
    output logic signed [15:0]                mouse_x,
    output logic signed [15:0]                mouse_y,
    output logic signed [15:0]                mouse_z,
    output logic [15:0]                       mouse_buttons,
    output logic [1:0]                        button_changed,
    output logic [15:0]                       key_state,
    output logic [1:0]                        edge_code,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rcfu_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rcfu_pkg::DATA_W-1:0]  pwdata,
    output logic [rcfu_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    // The unpack below addresses fixed byte positions of the frame.
    localparam int FRAME_BYTES = rcfu_pkg::FRAME_USED_BYTES;

    // Configuration registers
    logic [rcfu_pkg::STICK_W-1:0] center_reg;
    logic [rcfu_pkg::DEAD_W-1:0]  dead_reg;
    logic                         cfg_write;
    rcfu_pkg::reg_idx_t           cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = rcfu_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= rcfu_pkg::CENTER_RESET;
            dead_reg   <= rcfu_pkg::DEAD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                rcfu_pkg::REG_STICK_CENTER: center_reg <= pwdata[rcfu_pkg::STICK_W-1:0];
                rcfu_pkg::REG_DEADBAND:     dead_reg   <= pwdata[rcfu_pkg::DEAD_W-1:0];
                default:                    center_reg <= center_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_idx)
            rcfu_pkg::REG_STICK_CENTER:
                prdata = {{(rcfu_pkg::DATA_W-rcfu_pkg::STICK_W){1'b0}}, center_reg};
            rcfu_pkg::REG_DEADBAND:
                prdata = {{(rcfu_pkg::DATA_W-rcfu_pkg::DEAD_W){1'b0}}, dead_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake: only items that make a result wait for the output register.
    logic item_accept;
    logic makes_result;
    logic is_query;
    logic load_result;

    assign is_query     = (rcfu_pkg::cmd_t'(command) == rcfu_pkg::CMD_KEY_QUERY);
    assign makes_result = is_query || frame_end;
    assign item_stall   = result_valid && result_stall && makes_result;
    assign item_accept  = item_valid && !item_stall;
    assign load_result  = item_accept && makes_result;

    // Row of byte cells with a walking write token
    rcfu_pkg::cell_ctrl_t       cell_ctrl;
    logic [7:0]                 frame_next [FRAME_BYTES];
    logic [FRAME_BYTES-1:0]     token;

    assign cell_ctrl.shift   = item_accept && !is_query;
    assign cell_ctrl.restart = item_accept && !is_query && frame_end;

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_BYTES; gi++)
        begin : g_cell
            rcfu_cell #(
                .IS_HEAD (gi == 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .byte_in   (frame_byte),
                .token_in  ((gi == 0) ? 1'b0 : token[(gi == 0) ? 0 : gi-1]),
                .token_out (token[gi]),
                .byte_out  (frame_next[gi])
            );
        end
    endgenerate

    // Unpack the stick channels from the store view that includes this byte
    logic [rcfu_pkg::STICK_W-1:0]      raw [4];
    logic signed [rcfu_pkg::OFF_W-1:0] offset [4];

    assign raw[0] = {frame_next[1][2:0], frame_next[0]};
    assign raw[1] = {frame_next[2][5:0], frame_next[1][7:3]};
    assign raw[2] = {frame_next[4][0], frame_next[3], frame_next[2][7:6]};
    assign raw[3] = {frame_next[5][3:0], frame_next[4][7:1]};

    generate
        for (gi = 0; gi < 4; gi++)
        begin : g_stick
            rcfu_stick u_stick (
                .raw      (raw[gi]),
                .center   (center_reg),
                .deadband (dead_reg),
                .offset   (offset[gi])
            );
        end
    endgenerate

    // Key and mouse-button tracking
    logic [7:0]               left_reg;
    logic [7:0]               right_reg;
    logic [rcfu_pkg::KEY_W-1:0] key_reg;
    logic [rcfu_pkg::KEY_W-1:0] pending_reg;
    logic [rcfu_pkg::KEY_W-1:0] key_new;
    logic [1:0]               changed;
    logic [rcfu_pkg::KEY_W-1:0] hit;
    rcfu_pkg::edge_code_t     answer;

    assign key_new = {frame_next[15], frame_next[14]};
    assign changed = {frame_next[13] != right_reg, frame_next[12] != left_reg};
    assign hit     = pending_reg & key_mask;

    always_comb
    begin
        if (hit == '0)
        begin
            answer = rcfu_pkg::EDGE_NONE;
        end
        else if ((key_reg & key_mask) != '0)
        begin
            answer = rcfu_pkg::EDGE_RISE;
        end
        else
        begin
            answer = rcfu_pkg::EDGE_FALL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg    <= 8'd0;
            right_reg   <= 8'd0;
            key_reg     <= '0;
            pending_reg <= '0;
        end
        else if (item_accept && is_query)
        begin
            pending_reg <= pending_reg & ~key_mask;
        end
        else if (cell_ctrl.restart)
        begin
            left_reg    <= frame_next[12];
            right_reg   <= frame_next[13];
            key_reg     <= key_new;
            pending_reg <= pending_reg | (key_reg ^ key_new);
        end
    end

    // Output register
    logic result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            if (is_query)
            begin
                stick_a        <= '0;
                stick_b        <= '0;
                stick_c        <= '0;
                stick_d        <= '0;
                switches       <= '0;
                mouse_x        <= '0;
                mouse_y        <= '0;
                mouse_z        <= '0;
                mouse_buttons  <= '0;
                button_changed <= '0;
                key_state      <= '0;
                edge_code      <= answer;
            end
            else
            begin
                stick_a        <= offset[0];
                stick_b        <= offset[1];
                stick_c        <= offset[2];
                stick_d        <= offset[3];
                switches       <= frame_next[5][7:4];
                mouse_x        <= {frame_next[7], frame_next[6]};
                mouse_y        <= {frame_next[9], frame_next[8]};
                mouse_z        <= {frame_next[11], frame_next[10]};
                mouse_buttons  <= {frame_next[13], frame_next[12]};
                button_changed <= changed;
                key_state      <= key_new;
                edge_code      <= rcfu_pkg::EDGE_NONE;
            end
        end
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/rcfu_cell.sv
// One byte cell of the frame store, with the write token that walks the row.
`default_nettype none

module rcfu_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rcfu_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]         byte_in,
    input  wire logic               token_in,
    output logic                    token_out,
    output logic [7:0]              byte_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       token_reg;
    logic       token_next;

    // The cell holding the token takes the byte; the view includes that write.
    assign byte_next = (ctrl.shift && token_reg) ? byte_in : byte_reg;

    // The token moves one cell per byte and returns to the head at frame end.
    assign token_next = ctrl.restart ? IS_HEAD : token_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= 8'd0;
            token_reg <= IS_HEAD;
        end
        else if (ctrl.shift)
        begin
            byte_reg  <= byte_next;
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;
    assign byte_out  = byte_next;

endmodule

`default_nettype wire

FILE: rtl/rcfu_stick.sv
// Stick channel: signed offset from the center with a deadband.
`default_nettype none

module rcfu_stick (
    input  wire logic [rcfu_pkg::STICK_W-1:0] raw,
    input  wire logic [rcfu_pkg::STICK_W-1:0] center,
    input  wire logic [rcfu_pkg::DEAD_W-1:0]  deadband,
    output logic signed [rcfu_pkg::OFF_W-1:0] offset
);

    logic signed [rcfu_pkg::OFF_W-1:0] diff;
    logic        [rcfu_pkg::OFF_W-1:0] mag;

    // Difference fits in 12 bits; its magnitude is at most 2047.
    always_comb
    begin
        diff = $signed({1'b0, raw}) - $signed({1'b0, center});
        mag  = diff[rcfu_pkg::OFF_W-1] ? (~diff + 1'b1) : diff;
        if (mag <= {{(rcfu_pkg::OFF_W-rcfu_pkg::DEAD_W){1'b0}}, deadband})
        begin
            offset = '0;
        end
        else
        begin
            offset = diff;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rcfu_checker.sv
// Port-level checks for the frame unpacker, bound to the top level.
`default_nettype none

module rcfu_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire logic               command,
    input wire logic               frame_end,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic signed [11:0] stick_a,
    input wire logic signed [15:0] mouse_x,
    input wire logic [15:0]        key_state,
    input wire logic [1:0]         edge_code
);

    // A stalled result stays and keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(edge_code) &&
        $stable(stick_a) && $stable(key_state))
        else $error("stalled result changed");

    // An accepted query shows next cycle with all frame fields zero.
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command |=>
        result_valid && stick_a == 12'sd0 && mouse_x == 16'sd0 && key_state == 16'd0)
        else $error("query result missing or not cleared");

    // A frame result always carries a zero edge code.
    a_frame_edge: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !command && frame_end |=>
        result_valid && edge_code == 2'd0)
        else $error("frame result missing or has edge code");

    // A frame byte without end, with the output empty, makes no result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !command && !frame_end && !result_valid |=>
        !result_valid)
        else $error("result appeared without cause");

    // The edge code never takes the unused value.
    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> edge_code != 2'd3)
        else $error("illegal edge code");

endmodule

bind rc_frame_unpack_edges rcfu_checker u_rcfu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stick_a      (stick_a),
    .mouse_x      (mouse_x),
    .key_state    (key_state),
    .edge_code    (edge_code)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the remote-control frame unpacker with key-edge tracking.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    // Data word of the configuration port.
    typedef logic [rcfu_pkg::DATA_W-1:0] apb_data_t;

    // One expected result, laid out like the result ports.
    typedef struct packed {
        logic signed [11:0]   stick_a;
        logic signed [11:0]   stick_b;
        logic signed [11:0]   stick_c;
        logic signed [11:0]   stick_d;
        logic [3:0]           switches;
        logic [15:0]          mouse_x;
        logic [15:0]          mouse_y;
        logic [15:0]          mouse_z;
        logic [15:0]          mouse_buttons;
        logic [1:0]           button_changed;
        logic [15:0]          key_state;
        rcfu_pkg::edge_code_t edge_code;
    } rc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        command = 1'b0;
    logic [7:0]  frame_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic [15:0] key_mask = 16'h0000;

    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [11:0] stick_a, stick_b, stick_c, stick_d;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x, mouse_y, mouse_z;
    logic [15:0]        mouse_buttons;
    logic [1:0]         button_changed;
    logic [15:0]        key_state;
    logic [1:0]         edge_code;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [rcfu_pkg::ADDR_W-1:0] paddr = '0;
    apb_data_t                   pwdata = '0;
    apb_data_t                   prdata;
    logic                        pready;

    // Shadow state of the unpacker.
    logic [7:0]  frame_mem [rcfu_pkg::FRAME_USED_BYTES];
    int          byte_idx;
    logic [7:0]  last_left, last_right;
    logic [15:0] key_word, pending_keys;
    logic [10:0] center_reg;
    logic [5:0]  dead_reg;

    rc_result_t results_due [$];
    logic [7:0] frame_img [20];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  cycles = 0;
    bit  no_gaps = 1'b0;

    rc_frame_unpack_edges uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .command(command), .frame_byte(frame_byte), .frame_end(frame_end),
        .key_mask(key_mask),
        .result_valid(result_valid), .result_stall(result_stall),
        .stick_a(stick_a), .stick_b(stick_b), .stick_c(stick_c), .stick_d(stick_d),
        .switches(switches), .mouse_x(mouse_x), .mouse_y(mouse_y), .mouse_z(mouse_z),
        .mouse_buttons(mouse_buttons), .button_changed(button_changed),
        .key_state(key_state), .edge_code(edge_code),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock and run-length guard.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side stalls at random unless a gap-free stretch is running.
    always @(posedge clk)
    begin
        result_stall <= !no_gaps && ($urandom_range(99) < 13);
    end

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("[%0d] MISMATCH %s", cycles, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        rc_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (results_due.size() == 0)
                flag_mismatch("result with no expectation pending");
            else
            begin
                want = results_due.pop_front();
                check_field("stick_a", 16'(stick_a), 16'(want.stick_a));
                check_field("stick_b", 16'(stick_b), 16'(want.stick_b));
                check_field("stick_c", 16'(stick_c), 16'(want.stick_c));
                check_field("stick_d", 16'(stick_d), 16'(want.stick_d));
                check_field("switches", 16'(switches), 16'(want.switches));
                check_field("mouse_x", mouse_x, want.mouse_x);
                check_field("mouse_y", mouse_y, want.mouse_y);
                check_field("mouse_z", mouse_z, want.mouse_z);
                check_field("mouse_buttons", mouse_buttons, want.mouse_buttons);
                check_field("button_changed", 16'(button_changed), 16'(want.button_changed));
                check_field("key_state", key_state, want.key_state);
                check_field("edge_code", 16'(edge_code), 16'(want.edge_code));
            end
        end
    end

    // Signed offset of one raw stick from the center, with the deadband applied.
    function automatic logic [11:0] stick_offset(logic [10:0] raw);
        int off;
        int mag;
        off = int'(raw) - int'(center_reg);
        mag = (off < 0) ? -off : off;
        if (mag <= int'(dead_reg))
            off = 0;
        return off[11:0];
    endfunction

    // Advance the shadow state by one accepted item and queue any result it causes.
    function automatic void track_item(logic cmd, logic [7:0] fbyte, logic fend,
                                       logic [15:0] mask);
        rc_result_t r;
        logic [10:0] ch0, ch1, ch2, ch3;
        logic [15:0] kv;
        r = '0;
        if (cmd == rcfu_pkg::CMD_KEY_QUERY)
        begin
            r.edge_code = rcfu_pkg::EDGE_NONE;
            if ((pending_keys & mask) != 16'h0000)
            begin
                if ((key_word & mask) != 16'h0000)
                    r.edge_code = rcfu_pkg::EDGE_RISE;
                else
                    r.edge_code = rcfu_pkg::EDGE_FALL;
                pending_keys = pending_keys & ~mask;
            end
            results_due.push_back(r);
            return;
        end
        if (byte_idx < rcfu_pkg::FRAME_USED_BYTES)
        begin
            frame_mem[byte_idx] = fbyte;
            byte_idx++;
        end
        if (!fend)
            return;
        byte_idx = 0;
        ch0 = {frame_mem[1][2:0], frame_mem[0]};
        ch1 = {frame_mem[2][5:0], frame_mem[1][7:3]};
        ch2 = {frame_mem[4][0], frame_mem[3], frame_mem[2][7:6]};
        ch3 = {frame_mem[5][3:0], frame_mem[4][7:1]};
        kv = {frame_mem[15], frame_mem[14]};
        r.stick_a = stick_offset(ch0);
        r.stick_b = stick_offset(ch1);
        r.stick_c = stick_offset(ch2);
        r.stick_d = stick_offset(ch3);
        r.switches = frame_mem[5][7:4];
        r.mouse_x = {frame_mem[7], frame_mem[6]};
        r.mouse_y = {frame_mem[9], frame_mem[8]};
        r.mouse_z = {frame_mem[11], frame_mem[10]};
        r.mouse_buttons = {frame_mem[13], frame_mem[12]};
        r.button_changed = {frame_mem[13] != last_right, frame_mem[12] != last_left};
        r.key_state = kv;
        results_due.push_back(r);
        last_left = frame_mem[12];
        last_right = frame_mem[13];
        pending_keys = pending_keys | (key_word ^ kv);
        key_word = kv;
    endfunction

    // Offer one item, with random idle cycles first, and wait until it is taken.
    task automatic send_item(logic cmd, logic [7:0] fbyte, logic fend, logic [15:0] mask);
        while (!no_gaps && ($urandom_range(99) < 13))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        command <= cmd;
        frame_byte <= fbyte;
        frame_end <= fend;
        key_mask <= mask;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        track_item(cmd, fbyte, fend, mask);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_mask();
        case ($urandom_range(3))
            0: return 16'h0001 << $urandom_range(15);
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom & $urandom);
        endcase
    endfunction

    task automatic send_query(logic [15:0] mask);
        send_item(rcfu_pkg::CMD_KEY_QUERY, 8'($urandom), 1'($urandom), mask);
    endtask

    // Send the first len bytes of frame_img; stray queries may cut in between bytes.
    task automatic send_frame(int len, bit stray_queries);
        for (int i = 0; i < len; i++)
        begin
            if (stray_queries && ($urandom_range(99) < 3))
                send_query(pick_mask());
            send_item(rcfu_pkg::CMD_FRAME_BYTE, frame_img[i], i == len - 1, 16'($urandom));
        end
    endtask

    // Fill frame_img with a plausible frame: sticks near the center, at the ends or random,
    // buttons that often repeat, and keys that mostly change at most two bits at a time.
    task automatic build_frame(bit noise);
        logic [10:0] ch [4];
        logic [7:0]  left, right;
        logic [15:0] keys;
        int v;
        int dz;
        for (int i = 0; i < 20; i++)
            frame_img[i] = 8'($urandom);
        if (noise)
            return;
        dz = int'(dead_reg);
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    v = int'(center_reg) + int'($urandom_range(2 * dz + 4)) - (dz + 2);
                    if (v < 0)
                        v = 0;
                    if (v > 2047)
                        v = 2047;
                    ch[k] = v[10:0];
                end
                5: ch[k] = 11'd0;
                6: ch[k] = 11'd2047;
                default: ch[k] = 11'($urandom);
            endcase
        end
        frame_img[0] = ch[0][7:0];
        frame_img[1] = {ch[1][4:0], ch[0][10:8]};
        frame_img[2] = {ch[2][1:0], ch[1][10:5]};
        frame_img[3] = ch[2][9:2];
        frame_img[4] = {ch[3][6:0], ch[2][10]};
        frame_img[5] = {4'($urandom), ch[3][10:7]};
        left = ($urandom_range(99) < 60) ? last_left : 8'($urandom);
        right = ($urandom_range(99) < 60) ? last_right : 8'($urandom);
        frame_img[12] = left;
        frame_img[13] = right;
        case ($urandom_range(4))
            0: keys = key_word;
            1: keys = 16'($urandom);
            default: keys = key_word ^ (16'h0001 << $urandom_range(15))
                                     ^ (16'h0001 << $urandom_range(15));
        endcase
        frame_img[14] = keys[7:0];
        frame_img[15] = keys[15:8];
    endtask

    // Mostly well-formed frames with queries between them; the rest short,
    // overlong or pure noise.
    task automatic run_random(int n_items);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                build_frame(1'b0);
                send_frame(rcfu_pkg::FRAME_USED_BYTES, 1'b1);
            end
            else if (pick < 73)
            begin
                build_frame(1'b0);
                send_frame($urandom_range(rcfu_pkg::FRAME_USED_BYTES - 1, 1), 1'b1);
            end
            else if (pick < 78)
            begin
                build_frame(1'b0);
                send_frame($urandom_range(20, rcfu_pkg::FRAME_USED_BYTES + 1), 1'b1);
            end
            else if (pick < 83)
            begin
                build_frame(1'b1);
                send_frame($urandom_range(20, 1), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                    send_query(pick_mask());
            end
        end
    endtask

    // Drop item_valid and let every expected result come out.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(rcfu_pkg::reg_idx_t idx, apb_data_t value);
        paddr <= {idx, 2'b00};
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == rcfu_pkg::REG_STICK_CENTER)
            center_reg = value[10:0];
        else
            dead_reg = value[5:0];
        @(posedge clk);
    endtask

    task automatic set_config(logic [10:0] center, logic [5:0] dead);
        wait_idle();
        reg_write(rcfu_pkg::REG_STICK_CENTER, apb_data_t'(center));
        reg_write(rcfu_pkg::REG_DEADBAND, apb_data_t'(dead));
    endtask

    // Directed frames and queries at reset settings: overlong frame, short frame,
    // and the no-edge and rising-edge query answers.
    task automatic test_directed_frames();
        send_query(16'hFFFF);
        for (int i = 0; i < 20; i++)
            frame_img[i] = (i < rcfu_pkg::FRAME_USED_BYTES) ? 8'hFF : 8'h00;
        send_frame(rcfu_pkg::FRAME_USED_BYTES + 2, 1'b0);
        send_query(16'h00FF);
        frame_img[0] = 8'h00;
        send_frame(1, 1'b0);
        send_query(16'h0000);
        send_query(16'h00FF);
        send_query(16'hFF00);
    endtask

    // Random traffic at the register extremes and at random settings.
    task automatic test_config_sweep();
        set_config(11'd0, 6'd63);
        run_random(300);
        set_config(11'd2047, 6'd0);
        run_random(300);
        set_config(11'($urandom), 6'($urandom));
        run_random(300);
        set_config(11'($urandom), 6'($urandom));
        run_random(300);
    endtask

    // One item per cycle on both sides with no idling at all.
    task automatic test_back_to_back();
        set_config(rcfu_pkg::CENTER_RESET, rcfu_pkg::DEAD_RESET);
        no_gaps = 1'b1;
        run_random(250);
        no_gaps = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < rcfu_pkg::FRAME_USED_BYTES; i++)
            frame_mem[i] = 8'h00;
        byte_idx = 0;
        last_left = 8'h00;
        last_right = 8'h00;
        key_word = 16'h0000;
        pending_keys = 16'h0000;
        center_reg = rcfu_pkg::CENTER_RESET;
        dead_reg = rcfu_pkg::DEAD_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_config_sweep();
        test_back_to_back();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rcfu_pkg.sv
rtl/rcfu_cell.sv
rtl/rcfu_stick.sv
rtl/rc_frame_unpack_edges.sv
rtl/rcfu_checker.sv
verif/tb.sv
